>>> hw/rtl/lzr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzr_pkg: shared types for the largest zero rectangle block
// Holds the queue entry passed from the front end to the walk engine.
// ---------------------------------------------------------------------------
package lzr_pkg;

    // configuration register indexes
    localparam logic CFG_FRAME_ROWS = 1'b0;
    localparam logic CFG_FRAME_COLS = 1'b1;

    // walk engine states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WALK,
        ST_EMIT
    } walk_state_t;

    // one classified pixel: position, zero flag, run width/height, frame end
    typedef struct packed {
        logic        is_zero;
        logic        is_last;
        logic [11:0] row;
        logic [11:0] col;
        logic [12:0] run_w;
        logic [12:0] run_h;
    } pix_cmd_t;

endpackage

>>> hw/rtl/lzr_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzr_front: pixel intake and classification
// Tracks the scan position, keeps row run widths and column run heights,
// and hands one command per pixel to the queue.
// ---------------------------------------------------------------------------
module lzr_front #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              restart,
    input  logic [8:0]        rows_cfg,
    input  logic [8:0]        cols_cfg,
    input  logic              pix_valid,
    output logic              pix_ready,
    input  logic [7:0]        pix_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output lzr_pkg::pix_cmd_t cmd
);
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [11:0] row_reg, row_next;
    logic [11:0] col_reg, col_next;
    logic [12:0] runw_reg, runw_next;
    logic [12:0] height_mem [MAX_COLS];
    logic [12:0] hrd_reg;
    logic [12:0] rows_eff, cols_eff;
    logic [11:0] r, c;
    logic [12:0] h, w;
    logic        fire;

    // clamp frame sizes
    always_comb begin
        if (rows_cfg == 9'd0) rows_eff = 13'd1;
        else if ({4'd0, rows_cfg} > 13'(MAX_ROWS)) rows_eff = 13'(MAX_ROWS);
        else rows_eff = {4'd0, rows_cfg};
        if (cols_cfg == 9'd0) cols_eff = 13'd1;
        else if ({4'd0, cols_cfg} > 13'(MAX_COLS)) cols_eff = 13'(MAX_COLS);
        else cols_eff = {4'd0, cols_cfg};
    end

    assign pix_ready = cmd_ready;
    assign cmd_valid = pix_valid;
    assign fire      = pix_valid && cmd_ready;

    // position wrap and run lengths
    always_comb begin
        if ({1'b0, row_reg} >= rows_eff || {1'b0, col_reg} >= cols_eff) begin
            r = '0;
            c = '0;
        end else begin
            r = row_reg;
            c = col_reg;
        end
        h = (r == '0) ? 13'd1 : hrd_reg + 13'd1;
        w = (c == '0) ? 13'd1 : runw_reg + 13'd1;
        cmd.is_zero = (pix_data == 8'd0);
        cmd.row     = r;
        cmd.col     = c;
        cmd.run_w   = cmd.is_zero ? w : '0;
        cmd.run_h   = cmd.is_zero ? h : '0;
        cmd.is_last = ({1'b0, c} + 13'd1 >= cols_eff) && ({1'b0, r} + 13'd1 >= rows_eff);
        runw_next   = cmd.run_w;
        if ({1'b0, c} + 13'd1 >= cols_eff) begin
            col_next = '0;
            row_next = cmd.is_last ? 12'd0 : r + 12'd1;
        end else begin
            col_next = c + 12'd1;
            row_next = r;
        end
    end

    // position registers
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            row_reg  <= '0;
            col_reg  <= '0;
            runw_reg <= '0;
        end else if (fire) begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            runw_reg <= runw_next;
        end
    end

    // column height store; the height of the next pixel's column is fetched ahead
    always_ff @(posedge aclk) begin
        if (fire) begin
            height_mem[c[CW-1:0]] <= cmd.run_h;
            if (col_next == c) hrd_reg <= cmd.run_h;
            else hrd_reg <= height_mem[col_next[CW-1:0]];
        end
    end
endmodule

>>> hw/rtl/lzr_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzr_queue: two-entry command queue
// Decouples the front end from the walk engine.
// ---------------------------------------------------------------------------
module lzr_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  lzr_pkg::pix_cmd_t in_cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output lzr_pkg::pix_cmd_t out_cmd
);
    lzr_pkg::pix_cmd_t mem_reg [2];
    logic              wp_reg, rp_reg;
    logic [1:0]        cnt_reg;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = mem_reg[rp_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (in_valid && in_ready) wp_reg <= ~wp_reg;
            if (out_valid && out_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'((in_valid && in_ready) ? 1 : 0)
                               - 2'((out_valid && out_ready) ? 1 : 0);
        end
    end

    // entries
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) mem_reg[wp_reg] <= in_cmd;
    end
endmodule

>>> hw/rtl/lzr_walk.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzr_walk: column walk engine
// Stores run widths, walks up the column one stored width per cycle and
// keeps the best rectangle; emits it at the end of each frame.
// ---------------------------------------------------------------------------
module lzr_walk #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              restart,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  lzr_pkg::pix_cmd_t cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [48:0]       res_data,
    output logic              busy
);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW = RW + CW;

    lzr_pkg::walk_state_t state_reg, state_next;
    lzr_pkg::pix_cmd_t    cur_reg;
    logic [12:0]          width_mem [MAX_ROWS * MAX_COLS];
    logic [12:0]          rd_reg;
    logic [12:0]          dh_reg, dh_next;
    logic [12:0]          minw_reg, minw_next;
    logic [24:0]          area_reg;
    logic [24:0]          area_c;
    logic [31:0]          corner_reg;
    logic [48:0]          out_reg;
    logic                 out_valid_reg;
    logic [11:0]          rd_row;
    logic [AW-1:0]        wr_addr, rd_addr;
    logic                 take, walk_done;

    assign take      = (state_reg == lzr_pkg::ST_IDLE) && cmd_valid;
    assign wr_addr   = {cmd.row[RW-1:0], cmd.col[CW-1:0]};
    assign rd_row    = cur_reg.row - dh_next[11:0];
    assign rd_addr   = {rd_row[RW-1:0], cur_reg.col[CW-1:0]};
    assign minw_next = (rd_reg < minw_reg) ? rd_reg : minw_reg;
    assign area_c    = 25'(dh_reg + 13'd1) * 25'(minw_next);
    assign dh_next   = (state_reg == lzr_pkg::ST_READ) ? 13'd0 : dh_reg + 13'd1;
    assign walk_done = (dh_reg + 13'd1 >= cur_reg.run_h)
                    || (dh_reg >= {1'b0, cur_reg.row});

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lzr_pkg::ST_IDLE: if (cmd_valid) begin
                if (cmd.is_zero) state_next = lzr_pkg::ST_READ;
                else if (cmd.is_last) state_next = lzr_pkg::ST_EMIT;
            end
            lzr_pkg::ST_READ: state_next = lzr_pkg::ST_WALK;
            lzr_pkg::ST_WALK: if (walk_done) begin
                state_next = cur_reg.is_last ? lzr_pkg::ST_EMIT : lzr_pkg::ST_IDLE;
            end
            lzr_pkg::ST_EMIT: if (!out_valid_reg || res_ready) state_next = lzr_pkg::ST_IDLE;
            default: state_next = lzr_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd_ready = (state_reg == lzr_pkg::ST_IDLE);
        busy      = (state_reg != lzr_pkg::ST_IDLE) || out_valid_reg;
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    // width store; rows are read back one per cycle during the walk
    always_ff @(posedge aclk) begin
        if (take) width_mem[wr_addr] <= cmd.run_w;
        rd_reg <= width_mem[rd_addr];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lzr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            area_reg      <= '0;
            corner_reg    <= '0;
        end else begin
            state_reg <= restart ? lzr_pkg::ST_IDLE : state_next;
            if (state_reg == lzr_pkg::ST_EMIT && (!out_valid_reg || res_ready)) begin
                out_valid_reg <= 1'b1;
            end else if (res_valid && res_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (restart) begin
                area_reg   <= '0;
                corner_reg <= '0;
            end else if (state_reg == lzr_pkg::ST_WALK && area_c > area_reg) begin
                area_reg   <= area_c;
                corner_reg <= {cur_reg.row[7:0] - dh_reg[7:0],
                               cur_reg.col[7:0] + 8'd1 - minw_next[7:0],
                               cur_reg.row[7:0], cur_reg.col[7:0]};
            end else if (state_reg == lzr_pkg::ST_EMIT && (!out_valid_reg || res_ready)) begin
                area_reg      <= '0;
                corner_reg    <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (take) cur_reg <= cmd;
        if (state_reg == lzr_pkg::ST_READ) minw_reg <= cur_reg.run_w;
        else if (state_reg == lzr_pkg::ST_WALK) minw_reg <= minw_next;
        if (state_reg == lzr_pkg::ST_READ || state_reg == lzr_pkg::ST_WALK) dh_reg <= dh_next;
        if (state_reg == lzr_pkg::ST_EMIT && (!out_valid_reg || res_ready)) begin
            out_reg <= {area_reg[16:0], corner_reg[7:0], corner_reg[15:8],
                        corner_reg[23:16], corner_reg[31:24]};
        end
    end
endmodule

>>> hw/rtl/largest_zero_rectangle.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// largest_zero_rectangle: largest all-zero rectangle in a raster image
//
// Pixels enter on the s_ stream, one 8-bit pixel per item, row by row.
// After the last pixel of a frame (frame_rows x frame_cols, set through
// the cfg_ write port) one item leaves on the m_ stream with the corners
// and area of the largest rectangle of zero pixels; ties keep the first.
// The walk engine takes a nonzero pixel in its idle state; a zero pixel with
// run height h passes a read state and walks up to h rows of its column, one
// width-store read per cycle, and an emit state ends a frame. It takes no new
// pixel before the last is done. A two-entry queue lets intake run ahead of
// the walk engine. The result sits in an output register; when the receiver
// stalls, the walk engine holds at the end of the next frame.
// Reset sets both frame sizes to 256 and clears the scan position and the
// best rectangle; the width and height stores need no clearing pass.
// Writing a register restarts the frame.
// ---------------------------------------------------------------------------
module largest_zero_rectangle #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // top_row, left_col, bottom_row, right_col, best_area
);
    logic [8:0]        rows_reg, cols_reg;
    logic              fq_valid, fq_ready, qw_valid, qw_ready;
    lzr_pkg::pix_cmd_t fq_cmd, qw_cmd;
    logic [48:0]       res_data;
    logic              walk_busy;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= 9'd256;
            cols_reg <= 9'd256;
        end else if (cfg_we) begin
            if (cfg_index == lzr_pkg::CFG_FRAME_ROWS) rows_reg <= cfg_wdata;
            else cols_reg <= cfg_wdata;
        end
    end

    lzr_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .restart(cfg_we),
        .rows_cfg(rows_reg), .cols_cfg(cols_reg),
        .pix_valid(s_tvalid), .pix_ready(s_tready), .pix_data(s_tdata),
        .cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd(fq_cmd)
    );

    lzr_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(fq_valid), .in_ready(fq_ready), .in_cmd(fq_cmd),
        .out_valid(qw_valid), .out_ready(qw_ready), .out_cmd(qw_cmd)
    );

    lzr_walk #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_walk (
        .aclk(aclk), .aresetn(aresetn), .restart(cfg_we),
        .cmd_valid(qw_valid), .cmd_ready(qw_ready), .cmd(qw_cmd),
        .res_valid(m_tvalid), .res_ready(m_tready), .res_data(res_data),
        .busy(walk_busy)
    );

    assign m_tdata = {7'd0, res_data};

    // result area never exceeds the largest frame size, MAX_ROWS x MAX_COLS
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[48:32] <= 17'(MAX_ROWS * MAX_COLS)))
        else $error("area out of range");

    // a result with zero area reports zero corners
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[48:32] == 17'd0) |-> (m_tdata[31:0] == 32'd0))
        else $error("corners without area");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped under stall");

    // idle walk engine means no pending result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> walk_busy)
        else $error("busy flag lost");
endmodule

>>> sim/largest_zero_rectangle_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// largest_zero_rectangle_tb: self-checking bench for the zero rectangle finder
// Streams raster frames of pixels, predicts the largest all-zero rectangle of
// each frame in a scoreboard, and compares every result item field by field.
// Frame sizes change between phases, and the two stream sides stall at random.
// ---------------------------------------------------------------------------
module largest_zero_rectangle_tb;

    typedef struct {
        logic [7:0]  top_row;
        logic [7:0]  left_col;
        logic [7:0]  bottom_row;
        logic [7:0]  right_col;
        logic [16:0] best_area;
    } rect_t;

    // rectangle predictor and store of expected rectangles
    class rect_scoreboard;
        logic [8:0] run_width [65536];
        logic [8:0] run_height [256];
        logic [8:0] rows_reg, cols_reg;
        int         row_at, col_at, best, best_top, best_left, best_bot, best_right;
        rect_t      pending [$];
        int         errors;

        function new();
            rows_reg = 9'd256;
            cols_reg = 9'd256;
            restart();
            errors = 0;
        endfunction

        function void restart();
            row_at = 0; col_at = 0; best = 0;
            best_top = 0; best_left = 0; best_bot = 0; best_right = 0;
        endfunction

        function int clamp(logic [8:0] v);
            if (v == 0) return 1;
            if (v > 256) return 256;
            return v;
        endfunction

        function void write_reg(logic idx, logic [8:0] val);
            if (idx == lzr_pkg::CFG_FRAME_ROWS) rows_reg = val;
            else cols_reg = val;
            restart();
        endfunction

        function void note_pixel(logic [7:0] pix);
            int rows, cols, r, c, h, w, minw, dh, wv, area;
            rect_t res;
            rows = clamp(rows_reg);
            cols = clamp(cols_reg);
            if (row_at >= rows || col_at >= cols) begin
                row_at = 0; col_at = 0;
            end
            r = row_at; c = col_at;
            if (pix != 0) begin
                run_width[r * 256 + c] = 9'd0;
                run_height[c] = 9'd0;
            end else begin
                h = (r == 0) ? 1 : int'(run_height[c]) + 1;
                w = (c == 0) ? 1 : int'(run_width[r * 256 + c - 1]) + 1;
                minw = w;
                run_height[c] = 9'(h);
                run_width[r * 256 + c] = 9'(w);
                for (dh = 0; dh < h && dh <= r; dh++) begin
                    wv = run_width[(r - dh) * 256 + c];
                    if (wv < minw) minw = wv;
                    area = (dh + 1) * minw;
                    if (area > best) begin
                        best = area;
                        best_top = r - dh;
                        best_left = c + 1 - minw;
                        best_bot = r;
                        best_right = c;
                    end
                end
            end
            col_at = c + 1;
            if (col_at >= cols) begin
                col_at = 0;
                row_at = r + 1;
                if (row_at >= rows) begin
                    res.top_row = best_top[7:0];
                    res.left_col = best_left[7:0];
                    res.bottom_row = best_bot[7:0];
                    res.right_col = best_right[7:0];
                    res.best_area = best[16:0];
                    pending.push_back(res);
                    restart();
                end
            end
        endfunction

        task report(string what, int got, int want);
            $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check(logic [55:0] data);
            rect_t e;
            if (pending.size() == 0) begin
                report("unexpected result, area", int'(data[48:32]), 0);
                return;
            end
            e = pending.pop_front();
            if (data[7:0] !== e.top_row) report("top_row", data[7:0], e.top_row);
            if (data[15:8] !== e.left_col) report("left_col", data[15:8], e.left_col);
            if (data[23:16] !== e.bottom_row) report("bottom_row", data[23:16], e.bottom_row);
            if (data[31:24] !== e.right_col) report("right_col", data[31:24], e.right_col);
            if (data[48:32] !== e.best_area) report("best_area", data[48:32], e.best_area);
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic        cfg_index = 0;
    logic [8:0]  cfg_wdata = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;   // pixel
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;       // top_row, left_col, bottom_row, right_col, best_area

    rect_scoreboard sb = new();
    int  src_idle = 13, snk_idle = 69;
    int  hold_req = 0, hold_seen = 0, hold_left = 0;
    int  sent = 0;
    longint cycles = 0;

    largest_zero_rectangle DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > 2000000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: check accepted items, random stalls and one long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check(m_tdata);
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = 3000;
        end
        if (!aresetn) m_tready <= 1'b0;
        else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else m_tready <= ($urandom_range(99) >= snk_idle);
    end

    task send_pixel(input logic [7:0] pix);
        // idling pattern shifts by thirds of the run
        if (sent >= 700) begin
            src_idle = 0; snk_idle = 0;
        end else if (sent >= 350) begin
            src_idle = 69; snk_idle = 13;
        end
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pix;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_pixel(pix);
        sent++;
    endtask

    // wait until every rectangle is in, then let the walk engine settle
    task drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    task write_reg(input logic idx, input logic [8:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task set_size(input logic [8:0] rows, input logic [8:0] cols);
        drain();
        write_reg(lzr_pkg::CFG_FRAME_ROWS, rows);
        write_reg(lzr_pkg::CFG_FRAME_COLS, cols);
    endtask

    // random frames; zero_pct sets how free the image is
    task send_frames(input int nframes, input int zero_pct);
        int n, k;
        n = sb.clamp(sb.rows_reg) * sb.clamp(sb.cols_reg) * nframes;
        for (k = 0; k < n; k++)
            send_pixel(($urandom_range(99) < zero_pct) ? 8'd0 : 8'($urandom_range(1, 255)));
    endtask

    initial begin
        int rows, cols;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single pixel frames: free, and nonzero with every bit level
        write_reg(lzr_pkg::CFG_FRAME_ROWS, 9'd1);
        write_reg(lzr_pkg::CFG_FRAME_COLS, 9'd1);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'h01);
        send_pixel(8'h80);
        // ties keep the first rectangle found
        set_size(9'd1, 9'd3);
        send_pixel(8'd0); send_pixel(8'd7); send_pixel(8'd0);
        // all free 2x2, then an all-busy 2x2 frame
        set_size(9'd2, 9'd2);
        repeat (4) send_pixel(8'd0);
        repeat (4) send_pixel(8'($urandom_range(1, 255)));
        // zero size acts as one
        set_size(9'd0, 9'd0);
        send_pixel(8'd0); send_pixel(8'd9);
        // mid-frame register write restarts the frame
        set_size(9'd4, 9'd4);
        send_pixel(8'd0); send_pixel(8'd0); send_pixel(8'd3);
        set_size(9'd3, 9'd2);
        send_frames(1, 60);
        // oversize acts as 256: tallest column and widest row
        set_size(9'd511, 9'd1);
        repeat (256) send_pixel(8'd0);
        set_size(9'd1, 9'd300);
        repeat (256) send_pixel(8'd0);
        set_size(9'd256, 9'd1);
        send_frames(1, 90);

        // random part
        while (sent < 1050) begin
            rows = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 6);
            cols = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 6);
            set_size(rows[8:0], cols[8:0]);
            if (hold_req == 0) begin
                // receiver holds off while small frames keep coming
                set_size(9'd1, 9'd1);
                hold_req = 1;
                send_frames(30, 50);
            end else send_frames($urandom_range(1, 4), $urandom_range(50, 95));
        end
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/lzr_pkg.sv
hw/rtl/lzr_front.sv
hw/rtl/lzr_queue.sv
hw/rtl/lzr_walk.sv
hw/rtl/largest_zero_rectangle.sv
sim/largest_zero_rectangle_tb.sv
